// ----- design/drm_pkg.sv -----
// Shared widths, constants and queue item type for the decaying rate meter.
package drm_pkg;

   localparam int SEC_W    = 32;
   localparam int USEC_W   = 20;
   localparam int AMOUNT_W = 32;
   localparam int RATE_W   = 32;
   localparam int TOTAL_W  = 64;
   localparam int TICK_W   = 32;

   // The microsecond field times seven needs three more bits.
   localparam int USEC7_W  = USEC_W + 3;
   localparam int FRAC_W   = 3;

   localparam int unsigned TICKS_PER_SEC   = 7;
   localparam int unsigned USEC_PER_SEC    = 1000000;
   localparam int unsigned MAX_DECAY_TICKS = 166;
   localparam int unsigned DECAY_SHIFT     = 3;
   localparam logic [RATE_W-1:0] BIG_RATE  = 32'h0FFF_FFFF;

   // Step counter covers every difference up to the decay limit.
   localparam int STEP_W = $clog2(MAX_DECAY_TICKS + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [TICK_W-1:0]   now_tick;
      logic [AMOUNT_W-1:0] amount;
   } item_type;

endpackage

// ----- design/drm_if.sv -----
// Valid/ready channel interfaces for the request and response beats.
interface drm_req_if;
   logic                          valid;
   logic                          ready;
   logic [drm_pkg::SEC_W-1:0]     seconds;
   logic [drm_pkg::USEC_W-1:0]    microseconds;
   logic [drm_pkg::AMOUNT_W-1:0]  amount;

   modport source (output valid, output seconds, output microseconds, output amount,
                   input ready);
   modport sink   (input valid, input seconds, input microseconds, input amount,
                   output ready);
endinterface

interface drm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [drm_pkg::RATE_W-1:0]    rate_per_second;
   logic [drm_pkg::TOTAL_W-1:0]   grand_total;

   modport source (output valid, output rate_per_second, output grand_total,
                   input ready);
   modport sink   (input valid, input rate_per_second, input grand_total,
                   output ready);
endinterface

// ----- design/decaying_rate_meter_core.sv -----
// A request beat passes the front-end stage register and the queue; the decay engine
// then emits at once if the gap exceeds 166 ticks, else first runs the decay loop, one
// step per cycle for each tick of gap (at most 166), and takes a new item only after
// emitting; the front end and a two-entry queue keep taking request beats meanwhile.
// Reset (synchronous, active high) clears rate, total and last tick to zero and
// empties the queue and the output register.
module decaying_rate_meter_core (
   input  logic      clock,
   input  logic      reset,
   drm_req_if.sink   req_chan,
   drm_rsp_if.source rsp_chan
);

   logic              push_valid, push_ready;
   drm_pkg::item_type push_item;
   logic              pop_valid, pop_ready;
   drm_pkg::item_type pop_item;

   drm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   drm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   drm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- design/drm_front.sv -----
// Front end: accepts request beats, converts the timestamp to ticks and holds one item.
module drm_front (
   input  logic               clock,
   input  logic               reset,
   drm_req_if.sink            req_chan,
   output logic               push_valid,
   output drm_pkg::item_type  push_item,
   input  logic               push_ready
);

   logic              stage_valid_ff, stage_valid_in;
   drm_pkg::item_type stage_item_ff,  stage_item_in;
   logic              accept;

   function automatic logic [drm_pkg::TICK_W-1:0] tick_of(
      input logic [drm_pkg::SEC_W-1:0]  sec,
      input logic [drm_pkg::USEC_W-1:0] usec
   );
      logic [drm_pkg::USEC7_W-1:0] usec7;
      logic [drm_pkg::FRAC_W-1:0]  frac;
      logic [drm_pkg::TICK_W-1:0]  sec7;
      usec7 = {usec, 3'b000} - drm_pkg::USEC7_W'(usec);
      frac  = '0;
      // The fraction is the number of whole sevenths of a second reached.
      for (int k = 1; k <= drm_pkg::TICKS_PER_SEC; k++) begin
         if (usec7 >= drm_pkg::USEC7_W'(drm_pkg::USEC_PER_SEC * k)) begin
            frac = frac + drm_pkg::FRAC_W'(1);
         end
      end
      sec7 = {sec[drm_pkg::SEC_W-4:0], 3'b000} - sec;
      return sec7 + drm_pkg::TICK_W'(frac);
   endfunction

   assign req_chan.ready = !stage_valid_ff || push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push_valid     = stage_valid_ff;
   assign push_item      = stage_item_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_item_in  = stage_item_ff;
      if (stage_valid_ff && push_ready) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in         = 1'b1;
         stage_item_in.now_tick = tick_of(req_chan.seconds, req_chan.microseconds);
         stage_item_in.amount   = req_chan.amount;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_item_ff <= stage_item_in;
   end

endmodule

// ----- design/drm_queue.sv -----
// Short item queue that decouples the front end from the decay engine.
module drm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  drm_pkg::item_type  push_item,
   output logic               push_ready,
   output logic               pop_valid,
   output drm_pkg::item_type  pop_item,
   input  logic               pop_ready
);

   drm_pkg::item_type                  slots_ff [drm_pkg::QUEUE_DEPTH];
   logic [drm_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [drm_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [drm_pkg::QUEUE_CNT_W-1:0]    count_ff,  count_in;
   logic                               do_push, do_pop;

   assign push_ready = count_ff != drm_pkg::QUEUE_CNT_W'(drm_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == drm_pkg::QUEUE_PTR_W'(drm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + drm_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == drm_pkg::QUEUE_PTR_W'(drm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + drm_pkg::QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + drm_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - drm_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- design/drm_back.sv -----
// Decay engine: updates the meter state one tick per cycle and drives the response beat.
module drm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  drm_pkg::item_type  pop_item,
   output logic               pop_ready,
   drm_rsp_if.source          rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECAY,
      ST_EMIT
   } state_type;

   state_type                        state_ff,     state_in;
   logic [drm_pkg::RATE_W-1:0]       rate_ff,      rate_in;
   logic [drm_pkg::TOTAL_W-1:0]      total_ff,     total_in;
   logic [drm_pkg::TICK_W-1:0]       last_tick_ff, last_tick_in;
   logic [drm_pkg::RATE_W-1:0]       work_ff,      work_in;
   logic [drm_pkg::STEP_W-1:0]       steps_ff,     steps_in;
   logic [drm_pkg::AMOUNT_W-1:0]     amount_ff,    amount_in;
   logic                             out_valid_ff, out_valid_in;
   logic [drm_pkg::RATE_W-1:0]       out_rate_ff,  out_rate_in;
   logic [drm_pkg::TOTAL_W-1:0]      out_total_ff, out_total_in;
   logic [drm_pkg::TICK_W-1:0]       diff;
   logic [drm_pkg::RATE_W-1:0]       decrement;

   function automatic logic [drm_pkg::RATE_W-1:0] scale_rate(
      input logic [drm_pkg::RATE_W-1:0] r
   );
      logic [drm_pkg::RATE_W-1:0] eighth;
      logic [drm_pkg::RATE_W-1:0] times7;
      eighth = r >> drm_pkg::DECAY_SHIFT;
      times7 = {r[drm_pkg::RATE_W-4:0], 3'b000} - r;
      if (r > drm_pkg::BIG_RATE) begin
         return {eighth[drm_pkg::RATE_W-4:0], 3'b000} - eighth;
      end
      // Small rates keep seven times their value within 31 bits.
      return (times7 + drm_pkg::RATE_W'(7)) >> drm_pkg::DECAY_SHIFT;
   endfunction

   assign pop_ready = (state_ff == ST_IDLE);
   assign diff      = pop_item.now_tick - last_tick_ff;
   // Ceiling of an eighth of the working rate.
   assign decrement = (work_ff >> drm_pkg::DECAY_SHIFT) +
                      drm_pkg::RATE_W'(work_ff[2:0] != 3'b000);

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.rate_per_second = out_rate_ff;
   assign rsp_chan.grand_total     = out_total_ff;

   always_comb begin
      state_in     = state_ff;
      rate_in      = rate_ff;
      total_in     = total_ff;
      last_tick_in = last_tick_ff;
      work_in      = work_ff;
      steps_in     = steps_ff;
      amount_in    = amount_ff;
      out_valid_in = out_valid_ff;
      out_rate_in  = out_rate_ff;
      out_total_in = out_total_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               total_in     = total_ff + drm_pkg::TOTAL_W'(pop_item.amount);
               last_tick_in = pop_item.now_tick;
               amount_in    = pop_item.amount;
               if (diff > drm_pkg::TICK_W'(drm_pkg::MAX_DECAY_TICKS)) begin
                  // A long gap or time going backwards restarts the rate.
                  rate_in  = pop_item.amount;
                  state_in = ST_EMIT;
               end else begin
                  work_in  = rate_ff;
                  steps_in = diff[drm_pkg::STEP_W-1:0];
                  state_in = ST_DECAY;
               end
            end
         end
         ST_DECAY: begin
            if (steps_ff == '0 || work_ff == '0) begin
               rate_in  = work_ff + amount_ff;
               state_in = ST_EMIT;
            end else begin
               work_in  = work_ff - decrement;
               steps_in = steps_ff - drm_pkg::STEP_W'(1);
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_rate_in  = scale_rate(rate_ff);
               out_total_in = total_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= '0;
         total_ff     <= '0;
         last_tick_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         total_ff     <= total_in;
         last_tick_ff <= last_tick_in;
         out_valid_ff <= out_valid_in;
      end
      work_ff      <= work_in;
      steps_ff     <= steps_in;
      amount_ff    <= amount_in;
      out_rate_ff  <= out_rate_in;
      out_total_ff <= out_total_in;
   end

endmodule
